// File: sv/ntlf_pkg.sv
// Shared types and constants for the NVRAM text line filter.
package ntlf_pkg;

	localparam int LEN_W          = 17;
	localparam int MAX_POOL_BYTES = 65536;
	localparam int MAX_RES        = 4;
	localparam int RES_CNT_W      = $clog2(MAX_RES + 1);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       is_last;
	} ntlf_in_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic             end_of_pool;
		logic             overflow;
		logic [LEN_W-1:0] pool_length;
	} ntlf_out_t;

	// All results caused by one input beat, in delivery order.
	typedef struct packed {
		ntlf_out_t [MAX_RES-1:0] res;
		logic [RES_CNT_W-1:0]    count;
	} ntlf_group_t;

endpackage

// File: sv/ntlf_filter.sv
// Line filter state and per-beat result group computation.
module ntlf_filter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  ntlf_pkg::ntlf_in_t        in_data,
	input  logic [ntlf_pkg::LEN_W-1:0] capacity,
	output ntlf_pkg::ntlf_group_t     group
);
	import ntlf_pkg::*;

	localparam logic [1:0] PH_LEAD = 2'd0;
	localparam logic [1:0] PH_TEXT = 2'd1;
	localparam logic [1:0] PH_SKIP = 2'd2;

	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_NUL  = 8'h00;

	logic [1:0]       phase_q;
	logic             pcr_q;
	logic [LEN_W-1:0] count_q;
	logic             ovf_q;

	logic [1:0]                 ph;
	logic                       pcr;
	logic                       stop;
	logic [7:0]                 c;
	logic [MAX_RES-1:0][7:0]    cand;
	logic [RES_CNT_W-1:0]       cnt;
	logic [LEN_W-1:0]           cap_eff;
	logic [LEN_W-1:0]           room;
	logic [RES_CNT_W-1:0]       nemit;
	logic                       ovf_any;
	logic [RES_CNT_W-1:0]       last_idx;

	// Candidate bytes in model order; capacity is applied afterward.
	always_comb begin
		ph   = phase_q;
		pcr  = pcr_q;
		stop = 1'b0;
		c    = in_data.data_byte;
		cand = '0;
		cnt  = '0;
		if (in_data.byte_valid) begin
			if (pcr) begin
				pcr = 1'b0;
				if (c == CH_LF) begin
					if (ph == PH_TEXT) begin
						cand[cnt[1:0]] = CH_NUL;
						cnt = cnt + 1'b1;
					end
					ph   = PH_LEAD;
					stop = 1'b1;
				end else if (ph != PH_SKIP) begin
					ph = PH_TEXT;
					cand[cnt[1:0]] = CH_CR;
					cnt = cnt + 1'b1;
				end
			end
			if (!stop) begin
				if (c == CH_LF) begin
					if (ph == PH_TEXT) begin
						cand[cnt[1:0]] = CH_NUL;
						cnt = cnt + 1'b1;
					end
					ph = PH_LEAD;
				end else if (ph == PH_SKIP) begin
					ph = PH_SKIP;
				end else if (c == CH_CR) begin
					pcr = 1'b1;
				end else if (ph == PH_LEAD && (c == CH_SP || c == CH_TAB)) begin
					ph = PH_LEAD;
				end else if (ph == PH_LEAD && c == CH_HASH) begin
					ph = PH_SKIP;
				end else begin
					ph = PH_TEXT;
					cand[cnt[1:0]] = c;
					cnt = cnt + 1'b1;
				end
			end
		end
		if (in_data.is_last) begin
			pcr = 1'b0;
			if (ph == PH_TEXT) begin
				cand[cnt[1:0]] = CH_NUL;
				cnt = cnt + 1'b1;
			end
			cand[cnt[1:0]] = CH_NUL;
			cnt = cnt + 1'b1;
		end
	end

	// Clip the candidates against the room left in the pool.
	always_comb begin
		cap_eff = (capacity > LEN_W'(MAX_POOL_BYTES)) ? LEN_W'(MAX_POOL_BYTES) : capacity;
		// no room once a lowered capacity is already reached
		room    = (count_q >= cap_eff) ? '0 : cap_eff - count_q;
		if (ovf_q) begin
			nemit   = '0;
			ovf_any = 1'b1;
		end else if ({{(LEN_W-RES_CNT_W){1'b0}}, cnt} > room) begin
			nemit   = room[RES_CNT_W-1:0];
			ovf_any = 1'b1;
		end else begin
			nemit   = cnt;
			ovf_any = 1'b0;
		end
		last_idx = nemit - 1'b1;
	end

	always_comb begin
		for (int i = 0; i < MAX_RES; i++) begin
			group.res[i].out_byte    = cand[i];
			group.res[i].end_of_pool = 1'b0;
			group.res[i].overflow    = 1'b0;
			group.res[i].pool_length = count_q + LEN_W'(i + 1);
		end
		group.count = nemit;
		if (in_data.is_last) begin
			if (ovf_any) begin
				group.res[nemit[1:0]].out_byte    = CH_NUL;
				group.res[nemit[1:0]].end_of_pool = 1'b1;
				group.res[nemit[1:0]].overflow    = 1'b1;
				group.res[nemit[1:0]].pool_length = '0;
				group.count = nemit + 1'b1;
			end else begin
				group.res[last_idx[1:0]].end_of_pool = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			pcr_q   <= 1'b0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (in_data.is_last) begin
				phase_q <= PH_LEAD;
				pcr_q   <= 1'b0;
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				phase_q <= ph;
				pcr_q   <= pcr;
				count_q <= count_q + {{(LEN_W-RES_CNT_W){1'b0}}, nemit};
				ovf_q   <= ovf_any;
			end
		end
	end

endmodule

// File: sv/ntlf_drain.sv
// Result group register and output sequencer, one beat per cycle while out_stall is low.
module ntlf_drain (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  ntlf_pkg::ntlf_group_t group,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	output ntlf_pkg::ntlf_out_t   out_data
);
	import ntlf_pkg::*;

	ntlf_group_t          grp_s1;
	logic [RES_CNT_W-1:0] cnt_s1;
	logic [1:0]           idx_q;
	logic                 fire;
	logic                 done;
	logic                 load;

	assign out_valid = (cnt_s1 != '0);
	assign out_data  = grp_s1.res[idx_q];
	assign fire      = out_valid && !out_stall;
	assign done      = fire && ({1'b0, idx_q} == (cnt_s1 - 1'b1));
	// Take a new beat while the last result of the current group leaves.
	assign in_stall  = out_valid && !done;
	assign load      = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (load) begin
			grp_s1 <= group;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1 <= '0;
			idx_q  <= '0;
		end else if (load) begin
			cnt_s1 <= group.count;
			idx_q  <= '0;
		end else if (done) begin
			cnt_s1 <= '0;
			idx_q  <= '0;
		end else if (fire) begin
			idx_q <= idx_q + 1'b1;
		end
	end

endmodule

// File: sv/nvram_text_line_filter_top.sv
// Top level of the NVRAM text line filter.
// Turns a text byte stream into a pool of NUL-terminated key=value lines, dropping
// leading blanks, comment and blank lines, trimming a CR before LF or end of input,
// and closing the pool with an extra NUL. An input beat is taken only while the group
// register is empty or its last result leaves; each beat yields zero to four result
// beats, delivered one per cycle from the group register while out_stall is low, and
// the next input beat is taken in the cycle its last result leaves. Capacity is
// set by the cfg write port (reset 4096, saturating at 65536 bytes); once the pool
// would pass it, bytes are suppressed and end of input gives one overflow report.
module nvram_text_line_filter_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  ntlf_pkg::ntlf_in_t         in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output ntlf_pkg::ntlf_out_t        out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [ntlf_pkg::LEN_W-1:0] cfg_data
);
	import ntlf_pkg::*;

	logic [LEN_W-1:0] capacity_q;
	ntlf_group_t      group;
	logic             accept;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= LEN_W'(4096);
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	ntlf_filter u_filter (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_data  (in_data),
		.capacity (capacity_q),
		.group    (group)
	);

	ntlf_drain u_drain (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.group     (group),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
